[sv/wft_pkg.sv]
// wft_pkg: shared constants for the word frequency table
// field widths, status codes and default sizes; no dependencies
package wft_pkg;

  localparam int unsigned MAX_ENTRIES_DEF    = 256;
  localparam int unsigned MAX_WORD_BYTES_DEF = 32;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_LONG = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

[sv/wft_in_if.sv]
// wft_in_if: byte request channel of the word frequency table
// depends on wft_pkg for field widths
interface wft_in_if;
  logic                       valid;
  logic                       ready;
  logic [wft_pkg::BYTE_W-1:0] char_byte;
  logic                       word_end;

  modport source (output valid, output char_byte, output word_end, input ready);
  modport sink   (input valid, input char_byte, input word_end, output ready);
endinterface

[sv/wft_out_if.sv]
// wft_out_if: result channel of the word frequency table
// depends on wft_pkg for field widths
interface wft_out_if;
  logic                        valid;
  logic                        ready;
  logic [wft_pkg::INDEX_W-1:0] entry_index;
  logic [wft_pkg::COUNT_W-1:0] new_count;
  logic                        is_new;
  logic [wft_pkg::STAT_W-1:0]  status;

  modport source (output valid, output entry_index, output new_count, output is_new,
                  output status, input ready);
  modport sink   (input valid, input entry_index, input new_count, input is_new,
                  input status, output ready);
endinterface

[sv/wft_cell.sv]
// wft_cell: one byte cell of the pending word shift chain
// holds a byte, hands it to the next cell and compares it with a stored byte
module wft_cell #(
  parameter int unsigned LEN_W = 6,
  parameter int unsigned IDX   = 0
) (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [wft_pkg::BYTE_W-1:0] byte_i,
  input  logic [LEN_W-1:0]           len_i,
  input  logic [wft_pkg::BYTE_W-1:0] row_byte_i,
  output logic [wft_pkg::BYTE_W-1:0] byte_o,
  output logic                       hit_o
);

  logic [wft_pkg::BYTE_W-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  // cells past the word length do not take part
  assign hit_o  = (len_i <= LEN_W'(IDX)) || (byte_q == row_byte_i);

endmodule

[sv/word_frequency_table_unit.sv]
// word_frequency_table_unit: distinct word counter built on a byte cell chain
// depends on wft_pkg, wft_in_if, wft_out_if and wft_cell
// a byte that does not end a word is taken while idle, one word in flight at a time
// word end: entries scanned one per cycle in SEARCH, then DONE loads the result
//   register; a too long word goes straight to DONE; a held result stalls it
// reset clears the entry count and the pending length; memories are not cleared
module word_frequency_table_unit #(
  parameter int unsigned MAX_ENTRIES    = wft_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned MAX_WORD_BYTES = wft_pkg::MAX_WORD_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wft_in_if.sink     in_i,
  wft_out_if.source  out_o
);

  localparam int unsigned LW    = $clog2(MAX_WORD_BYTES);
  localparam int unsigned LENW  = LW + 1;
  localparam int unsigned EW    = $clog2(MAX_ENTRIES);
  localparam int unsigned UW    = EW + 1;
  localparam int unsigned ROW_W = MAX_WORD_BYTES * wft_pkg::BYTE_W + LW;
  localparam int unsigned CW    = wft_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  localparam logic [1:0] K_HIT  = 2'd0;
  localparam logic [1:0] K_NEW  = 2'd1;
  localparam logic [1:0] K_FULL = 2'd2;
  localparam logic [1:0] K_LONG = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [LENW-1:0] len_q, len_d;
  logic [UW-1:0]   used_q, used_d;
  logic [UW-1:0]   scan_q, scan_d;
  logic            cmp_v_q, cmp_v_d;
  logic [EW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [1:0]      kind_q, kind_d;
  logic [EW-1:0]   hit_idx_q, hit_idx_d;
  logic [CW-1:0]   hit_cnt_q, hit_cnt_d;
  logic [ROW_W-1:0] rd_row_q;
  logic [CW-1:0]   rd_cnt_q;

  logic                           out_valid_q;
  logic [wft_pkg::INDEX_W-1:0]    out_idx_q, res_idx;
  logic [CW-1:0]                  out_cnt_q, res_cnt;
  logic                           out_new_q, res_new;
  logic [wft_pkg::STAT_W-1:0]     out_st_q, res_st;

  logic [ROW_W-1:0] row_mem [MAX_ENTRIES];
  logic [CW-1:0]    cnt_mem [MAX_ENTRIES];

  logic [wft_pkg::BYTE_W-1:0] cell_byte [MAX_WORD_BYTES];
  logic [MAX_WORD_BYTES-1:0]  cell_hit;
  logic [ROW_W-1:0]           wr_row;

  logic            accept, issue, row_hit, commit;
  logic [LENW-1:0] new_len;
  logic [CW-1:0]   inc_cnt;
  logic            cnt_we;
  logic [EW-1:0]   cnt_waddr;
  logic [CW-1:0]   cnt_wdata;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign new_len    = (len_q < LENW'(MAX_WORD_BYTES)) ? len_q + LENW'(1) : len_q;
  assign issue      = (state_q == S_SEARCH) && (scan_q < used_q);
  assign row_hit    = cmp_v_q && ({1'b0, rd_row_q[LW-1:0]} == len_q) && (&cell_hit);
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign inc_cnt    = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + CW'(1);

  // pending word chain, newest byte in cell 0
  for (genvar j = 0; j < MAX_WORD_BYTES; j++) begin : g_cell
    logic [wft_pkg::BYTE_W-1:0] chain_in;
    if (j == 0) begin : g_head
      assign chain_in = in_i.char_byte;
    end else begin : g_link
      assign chain_in = cell_byte[j-1];
    end
    wft_cell #(
      .LEN_W (LENW),
      .IDX   (j)
    ) u_cell (
      .clk_i      (clk_i),
      .shift_i    (accept),
      .byte_i     (chain_in),
      .len_i      (len_q),
      .row_byte_i (rd_row_q[LW + j*wft_pkg::BYTE_W +: wft_pkg::BYTE_W]),
      .byte_o     (cell_byte[j]),
      .hit_o      (cell_hit[j])
    );
  end

  always_comb begin
    wr_row = '0;
    wr_row[LW-1:0] = len_q[LW-1:0];
    for (int j = 0; j < MAX_WORD_BYTES; j++) begin
      wr_row[LW + j*wft_pkg::BYTE_W +: wft_pkg::BYTE_W] = cell_byte[j];
    end
  end

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    used_d    = used_q;
    scan_d    = scan_q;
    cmp_v_d   = cmp_v_q;
    cmp_idx_d = cmp_idx_q;
    kind_d    = kind_q;
    hit_idx_d = hit_idx_q;
    hit_cnt_d = hit_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          len_d = new_len;
          if (in_i.word_end) begin
            scan_d  = '0;
            cmp_v_d = 1'b0;
            if (new_len == LENW'(MAX_WORD_BYTES)) begin
              kind_d  = K_LONG;
              state_d = S_DONE;
            end else begin
              state_d = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        cmp_v_d   = issue;
        cmp_idx_d = scan_q[EW-1:0];
        if (issue) begin
          scan_d = scan_q + UW'(1);
        end
        if (row_hit) begin
          kind_d    = K_HIT;
          hit_idx_d = cmp_idx_q;
          hit_cnt_d = rd_cnt_q;
          state_d   = S_DONE;
        end else if (!issue && !cmp_v_q) begin
          kind_d  = (used_q == UW'(MAX_ENTRIES)) ? K_FULL : K_NEW;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_d = S_IDLE;
          len_d   = '0;
          if (kind_q == K_NEW) begin
            used_d = used_q + UW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_idx = '0;
    res_cnt = '0;
    res_new = 1'b0;
    res_st  = wft_pkg::ST_OK;
    case (kind_q)
      K_HIT: begin
        res_idx = wft_pkg::INDEX_W'(hit_idx_q);
        res_cnt = inc_cnt;
      end
      K_NEW: begin
        res_idx = wft_pkg::INDEX_W'(used_q[EW-1:0]);
        res_cnt = CW'(1);
        res_new = 1'b1;
      end
      K_FULL: begin
        res_st = wft_pkg::ST_FULL;
      end
      default: begin
        res_st = wft_pkg::ST_LONG;
      end
    endcase
  end

  always_comb begin
    cnt_we    = commit && ((kind_q == K_HIT) || (kind_q == K_NEW));
    cnt_waddr = (kind_q == K_HIT) ? hit_idx_q : used_q[EW-1:0];
    cnt_wdata = (kind_q == K_HIT) ? inc_cnt : CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_row_q <= row_mem[scan_q[EW-1:0]];
      rd_cnt_q <= cnt_mem[scan_q[EW-1:0]];
    end
    if (commit && (kind_q == K_NEW)) begin
      row_mem[used_q[EW-1:0]] <= wr_row;
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      used_q      <= '0;
      scan_q      <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      used_q  <= used_d;
      scan_q  <= scan_d;
      cmp_v_q <= cmp_v_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    kind_q    <= kind_d;
    hit_idx_q <= hit_idx_d;
    hit_cnt_q <= hit_cnt_d;
    if (commit) begin
      out_idx_q <= res_idx;
      out_cnt_q <= res_cnt;
      out_new_q <= res_new;
      out_st_q  <= res_st;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entry_index = out_idx_q;
  assign out_o.new_count   = out_cnt_q;
  assign out_o.is_new      = out_new_q;
  assign out_o.status      = out_st_q;

  a_search_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (len_q < LENW'(MAX_WORD_BYTES)))
    else $error("scan started on a word too long to store");

  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (kind_q == K_NEW)) |=> (used_q == $past(used_q) + UW'(1)))
    else $error("append did not grow the table");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (scan_q <= used_q))
    else $error("scan ran past the last entry");

endmodule

[verif/word_frequency_table_unit_tb.sv]
`timescale 1ns / 1ps
// word_frequency_table_unit_tb: self-checking bench for the word frequency table
// needs wft_pkg, wft_in_if, wft_out_if and the word_frequency_table_unit rtl
module word_frequency_table_unit_tb;

  localparam int unsigned NUM_ENTRIES = wft_pkg::MAX_ENTRIES_DEF;
  localparam int unsigned WORD_BYTES  = wft_pkg::MAX_WORD_BYTES_DEF;

  typedef logic [wft_pkg::BYTE_W-1:0] byte_q_t[$];

  typedef struct packed {
    logic [wft_pkg::INDEX_W-1:0] entry_index;
    logic [wft_pkg::COUNT_W-1:0] new_count;
    logic                        is_new;
    logic [wft_pkg::STAT_W-1:0]  status;
  } word_tally_t;

  // word is head0, head1, then fill up to len bytes
  typedef struct packed {
    logic [7:0]                 len;
    logic [wft_pkg::BYTE_W-1:0] head0;
    logic [wft_pkg::BYTE_W-1:0] head1;
    logic [wft_pkg::BYTE_W-1:0] fill;
    logic                       typed;
    word_tally_t                want;
  } word_row_t;

  logic clk_i;
  logic rst_ni;

  wft_in_if  in_if ();
  wft_out_if out_if ();

  word_frequency_table_unit #(
    .MAX_ENTRIES    (NUM_ENTRIES),
    .MAX_WORD_BYTES (WORD_BYTES)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow copy of the word table
  logic [wft_pkg::BYTE_W-1:0]  known_bytes [NUM_ENTRIES][WORD_BYTES];
  int unsigned                 known_len   [NUM_ENTRIES];
  logic [wft_pkg::COUNT_W-1:0] known_cnt   [NUM_ENTRIES];
  int unsigned                 used_entries = 0;
  logic [wft_pkg::BYTE_W-1:0]  pend_bytes  [WORD_BYTES];
  int unsigned                 pend_len     = 0;
  bit                          pend_over    = 1'b0;

  word_tally_t tally_q[$];

  int unsigned snd_idle_pct = 25;
  int unsigned rcv_idle_pct = 57;
  int unsigned bytes_sent   = 0;
  int unsigned words_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned fresh_seen   = 0;
  int unsigned repeat_seen  = 0;
  int unsigned long_seen    = 0;
  int unsigned full_seen    = 0;

  word_row_t dir_rows [13] = '{
    '{8'd1,  8'h61, 8'h00, 8'h00, 1'b1, '{8'd0, 32'd1, 1'b1, wft_pkg::ST_OK}},
    '{8'd1,  8'h61, 8'h00, 8'h00, 1'b1, '{8'd0, 32'd2, 1'b0, wft_pkg::ST_OK}},
    '{8'd1,  8'h00, 8'h00, 8'h00, 1'b1, '{8'd1, 32'd1, 1'b1, wft_pkg::ST_OK}},
    '{8'd2,  8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
    '{8'd2,  8'h61, 8'h62, 8'h00, 1'b0, '0},
    '{8'd2,  8'h61, 8'h00, 8'h00, 1'b0, '0},
    '{8'd31, 8'h80, 8'h80, 8'h80, 1'b0, '0},
    '{8'd32, 8'h80, 8'h80, 8'h80, 1'b1, '{8'd0, 32'd0, 1'b0, wft_pkg::ST_LONG}},
    '{8'd40, 8'h7F, 8'h7F, 8'h7F, 1'b1, '{8'd0, 32'd0, 1'b0, wft_pkg::ST_LONG}},
    '{8'd31, 8'h80, 8'h80, 8'h80, 1'b0, '0},
    '{8'd30, 8'h80, 8'h80, 8'h80, 1'b0, '0},
    '{8'd2,  8'h61, 8'h62, 8'h00, 1'b0, '0},
    '{8'd3,  8'h01, 8'h02, 8'h04, 1'b0, '0}
  };

  function automatic void count_word_byte(input logic [wft_pkg::BYTE_W-1:0] b,
                                          input logic last,
                                          output bit produced, output word_tally_t t);
    int  hit;
    bit  same;
    hit      = -1;
    t        = '0;
    produced = last;
    if (pend_len < WORD_BYTES) begin
      pend_bytes[pend_len] = b;
      pend_len++;
    end
    if (pend_len >= WORD_BYTES) pend_over = 1'b1;
    if (!last) return;
    if (pend_over) begin
      t.status = wft_pkg::ST_LONG;
    end else begin
      for (int e = 0; e < int'(used_entries) && hit < 0; e++) begin
        if (known_len[e] == pend_len) begin
          same = 1'b1;
          for (int k = 0; k < int'(pend_len); k++)
            if (known_bytes[e][k] != pend_bytes[k]) same = 1'b0;
          if (same) hit = e;
        end
      end
      if (hit >= 0) begin
        if (known_cnt[hit] != '1) known_cnt[hit]++;
        t.entry_index = wft_pkg::INDEX_W'(hit);
        t.new_count   = known_cnt[hit];
        t.status      = wft_pkg::ST_OK;
      end else if (used_entries >= NUM_ENTRIES) begin
        t.status = wft_pkg::ST_FULL;
      end else begin
        for (int k = 0; k < int'(pend_len); k++) known_bytes[used_entries][k] = pend_bytes[k];
        known_len[used_entries] = pend_len;
        known_cnt[used_entries] = 1;
        t.entry_index = wft_pkg::INDEX_W'(used_entries);
        t.new_count   = 1;
        t.is_new      = 1'b1;
        t.status      = wft_pkg::ST_OK;
        used_entries++;
      end
    end
    pend_len  = 0;
    pend_over = 1'b0;
  endfunction

  task automatic send_word(input byte_q_t word, input bit typed, input word_tally_t typed_tally);
    word_tally_t t;
    bit          produced;
    for (int i = 0; i < word.size(); i++) begin
      while ($urandom_range(0, 99) < snd_idle_pct) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_if.valid     <= 1'b1;
      in_if.char_byte <= word[i];
      in_if.word_end  <= (i == word.size() - 1);
      do @(posedge clk_i); while (in_if.ready !== 1'b1);
      bytes_sent++;
      count_word_byte(word[i], i == word.size() - 1, produced, t);
      if (produced) begin
        tally_q.push_back(typed ? typed_tally : t);
        words_sent++;
      end
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (tally_q.size() != 0);
  endtask

  task automatic run_words(input int unsigned nbytes, input int unsigned snd_pct,
                           input int unsigned rcv_pct);
    byte_q_t     w;
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int unsigned e;
    int unsigned new_cut;
    int unsigned k;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start        = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      w       = {};
      pick    = $urandom_range(0, 99);
      new_cut = (used_entries < NUM_ENTRIES) ? 75 : 35;
      if (pick < 3) begin
        len = $urandom_range(WORD_BYTES, WORD_BYTES + 8);
        repeat (len) w.push_back(wft_pkg::BYTE_W'($urandom_range(0, 255)));
      end else if (used_entries == 0 || pick < new_cut) begin
        len = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 3)
                                           : $urandom_range(4, WORD_BYTES - 1);
        repeat (len) w.push_back(wft_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        e = $urandom_range(0, used_entries - 1);
        for (int i = 0; i < int'(known_len[e]); i++) w.push_back(known_bytes[e][i]);
        // near miss: shorter, longer or one bit off
        if (pick >= 93) begin
          case ($urandom_range(0, 2))
            0: begin
              if (w.size() > 1) void'(w.pop_back());
              else w.push_back(wft_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            1: w.push_back(wft_pkg::BYTE_W'($urandom_range(0, 255)));
            default: begin
              k = $urandom_range(0, w.size() - 1);
              w[k] = w[k] ^ wft_pkg::BYTE_W'(1 << $urandom_range(0, wft_pkg::BYTE_W - 1));
            end
          endcase
        end
      end
      if ($urandom_range(0, 99) < 2) drain_results();
      send_word(w, 1'b0, '0);
    end
    drain_results();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        case (out_if.status)
          wft_pkg::ST_LONG: long_seen++;
          wft_pkg::ST_FULL: full_seen++;
          default: if (out_if.is_new) fresh_seen++; else repeat_seen++;
        endcase
        if (tally_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: index %0d count %0d new %0b status %0d",
                     out_if.entry_index, out_if.new_count, out_if.is_new, out_if.status);
        end else begin
          word_tally_t want;
          want = tally_q.pop_front();
          if (out_if.entry_index !== want.entry_index || out_if.new_count !== want.new_count ||
              out_if.is_new !== want.is_new || out_if.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"tally mismatch (exp/got): index %0d/%0d count %0d/%0d",
                        " new %0b/%0b st %0d/%0d"},
                       want.entry_index, out_if.entry_index, want.new_count, out_if.new_count,
                       want.is_new, out_if.is_new, want.status, out_if.status);
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  initial begin
    #(60_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    byte_q_t w;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.char_byte <= '0;
    in_if.word_end  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      w = {};
      for (int k = 0; k < int'(dir_rows[r].len); k++)
        w.push_back(k == 0 ? dir_rows[r].head0 : (k == 1 ? dir_rows[r].head1 : dir_rows[r].fill));
      send_word(w, dir_rows[r].typed, dir_rows[r].want);
    end
    drain_results();

    run_words(458, 25, 57);
    run_words(457, 57, 25);
    run_words(457, 0, 0);

    repeat (NUM_ENTRIES + 16) @(posedge clk_i);

    $display("covered %0d words in %0d bytes: %0d new entries, %0d repeats,",
             words_sent, bytes_sent, fresh_seen, repeat_seen);
    $display("%0d too long, %0d on a full table; table ended with %0d of %0d entries in use",
             long_seen, full_seen, used_entries, NUM_ENTRIES);
    if (mismatches == 0 && tally_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/wft_pkg.sv
sv/wft_in_if.sv
sv/wft_out_if.sv
sv/wft_cell.sv
sv/word_frequency_table_unit.sv
verif/word_frequency_table_unit_tb.sv
